// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the UTF-8 locator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check a property at every rising edge outside reset
`define U8LC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Check that a condition implies another in the next cycle
`define U8LC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define U8LC_ASSERT(label, clk, rst_n, prop)
`define U8LC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/u8lc_pkg.sv =====
// ----------------------------------------------------------------------------
// u8lc_pkg
// Types, constants and helpers for the UTF-8 offset to line/UTF-16 column
// locator.
// ----------------------------------------------------------------------------
package u8lc_pkg;

    localparam int COUNT_BITS_DEF = 32;
    localparam int TARGET_BITS    = 32;
    localparam int OUT_BITS       = 32;

    // Byte codes
    localparam logic [7:0] BYTE_LF   = 8'h0a;
    localparam logic [7:0] BYTE_CR   = 8'h0d;
    localparam logic [7:0] ASCII_END = 8'h80;
    localparam logic [7:0] LEAD2_LO  = 8'hc2;
    localparam logic [7:0] LEAD2_HI  = 8'hdf;
    localparam logic [7:0] LEAD3_LO  = 8'he0;
    localparam logic [7:0] LEAD3_HI  = 8'hef;
    localparam logic [7:0] LEAD4_LO  = 8'hf0;
    localparam logic [7:0] LEAD4_HI  = 8'hf4;
    localparam logic [7:0] CONT_MASK = 8'hc0;
    localparam logic [7:0] CONT_TAG  = 8'h80;

    // Scalar value limits
    localparam logic [20:0] SCALAR_MAX = 21'h10ffff;
    localparam logic [20:0] BMP_MAX    = 21'h00ffff;
    localparam logic [20:0] SURR_LO    = 21'h00d800;
    localparam logic [20:0] SURR_HI    = 21'h00dfff;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_UTF8 = 2'd1,
        ST_BOUNDARY = 2'd2
    } t_status;

    // Decoder state carried between bytes
    typedef struct packed {
        logic [1:0]  cont_left;
        logic [20:0] partial;
        logic [1:0]  lead_class;
        logic        after_cr;
        logic        target_found;
        logic        encoding_bad;
        logic        split_bad;
    } t_dec;

    // One input transaction as held in the input register
    typedef struct packed {
        logic [7:0] text_byte;
        logic       is_last;
        logic       text_empty;
    } t_item;

    // One result transaction
    typedef struct packed {
        logic [OUT_BITS-1:0] line_number;
        logic [OUT_BITS-1:0] utf16_column;
        t_status             status;
    } t_result;

    // Smallest legal scalar for each lead class (rejects overlong forms)
    function automatic logic [20:0] scalar_min(input logic [1:0] lead_class);
        logic [20:0] v;
        case (lead_class)
            2'd1:    v = 21'h000080;
            2'd2:    v = 21'h000800;
            2'd3:    v = 21'h010000;
            default: v = 21'h000000;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/u8lc_byte_if.sv =====
// ----------------------------------------------------------------------------
// u8lc_byte_if
// Byte channel: one text byte per transaction with end markers.
// ----------------------------------------------------------------------------
interface u8lc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       is_last;
    logic       text_empty;

    modport source (output valid, output text_byte, output is_last, output text_empty,
                    input ready);
    modport sink (input valid, input text_byte, input is_last, input text_empty,
                  output ready);
endinterface

// ===== rtl/u8lc_result_if.sv =====
// ----------------------------------------------------------------------------
// u8lc_result_if
// Result channel: line, UTF-16 column and status of the target offset.
// ----------------------------------------------------------------------------
interface u8lc_result_if;
    logic                          valid;
    logic                          ready;
    logic [u8lc_pkg::OUT_BITS-1:0] line_number;
    logic [u8lc_pkg::OUT_BITS-1:0] utf16_column;
    logic [1:0]                    status;

    modport source (output valid, output line_number, output utf16_column, output status,
                    input ready);
    modport sink (input valid, input line_number, input utf16_column, input status,
                  output ready);
endinterface

// ===== rtl/u8lc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// u8lc_cfg_if
// Configuration write channel for the target offset register.
// ----------------------------------------------------------------------------
interface u8lc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [u8lc_pkg::TARGET_BITS-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/u8lc_in_reg.sv =====
// ----------------------------------------------------------------------------
// u8lc_in_reg
// Input register: holds one byte transaction until the core takes it.
// ----------------------------------------------------------------------------
module u8lc_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    u8lc_byte_if.sink         i_text,
    input  logic              i_advance,
    output logic              o_valid,
    output u8lc_pkg::t_item   o_item
);

    logic            r_valid;
    u8lc_pkg::t_item r_item;
    logic            w_take;

    // Accept when empty or when the held transaction moves on this cycle
    assign i_text.ready = !r_valid || i_advance;
    assign w_take       = i_text.valid && i_text.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.text_byte  <= i_text.text_byte;
            r_item.is_last    <= i_text.is_last;
            r_item.text_empty <= i_text.text_empty;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/u8lc_step.sv =====
// ----------------------------------------------------------------------------
// u8lc_step
// Per-byte decode, counter update and end-of-text result selection.
// ----------------------------------------------------------------------------
module u8lc_step #(
    parameter int COUNT_BITS = u8lc_pkg::COUNT_BITS_DEF
) (
    input  u8lc_pkg::t_item                  i_item,
    input  logic [u8lc_pkg::TARGET_BITS-1:0] i_target,
    input  u8lc_pkg::t_dec                   i_dec,
    input  logic [COUNT_BITS-1:0]            i_byte_count,
    input  logic [COUNT_BITS-1:0]            i_line_count,
    input  logic [COUNT_BITS-1:0]            i_unit_count,
    input  logic [COUNT_BITS-1:0]            i_found_line,
    input  logic [COUNT_BITS-1:0]            i_found_column,
    output u8lc_pkg::t_dec                   o_dec,
    output logic [COUNT_BITS-1:0]            o_byte_count,
    output logic [COUNT_BITS-1:0]            o_line_count,
    output logic [COUNT_BITS-1:0]            o_unit_count,
    output logic [COUNT_BITS-1:0]            o_found_line,
    output logic [COUNT_BITS-1:0]            o_found_column,
    output logic                             o_end,
    output u8lc_pkg::t_result                o_result
);

    localparam int CMP_BITS = (COUNT_BITS > u8lc_pkg::TARGET_BITS) ?
                              COUNT_BITS : u8lc_pkg::TARGET_BITS;

    u8lc_pkg::t_dec        dn;
    logic [COUNT_BITS-1:0] bc, lc, uc, fl, fc;
    logic [7:0]            b;
    logic [20:0]           v;
    logic                  overflow, hit, do_count;
    logic [CMP_BITS-1:0]   w_target;

    assign w_target = CMP_BITS'(i_target);
    assign b        = i_item.text_byte;

    // Decode one byte and update the counters
    always_comb begin
        dn       = i_dec;
        bc       = i_byte_count;
        lc       = i_line_count;
        uc       = i_unit_count;
        fl       = i_found_line;
        fc       = i_found_column;
        v        = 21'd0;
        do_count = 1'b0;
        overflow = &i_byte_count;
        hit      = !overflow && (CMP_BITS'(i_byte_count) == w_target);

        if (!i_item.text_empty) begin
            // Saturate the byte position on an over-long text
            if (overflow) begin
                dn.split_bad = 1'b1;
            end else begin
                bc = i_byte_count + COUNT_BITS'(1);
            end

            if (i_dec.cont_left == 2'd0) begin
                if (i_dec.after_cr && b == u8lc_pkg::BYTE_LF) begin
                    // LF of a CRLF: line already counted
                    dn.after_cr = 1'b0;
                    if (hit) begin
                        dn.split_bad = 1'b1;
                    end
                end else begin
                    dn.after_cr = 1'b0;
                    if (hit && !i_dec.target_found) begin
                        dn.target_found = 1'b1;
                        fl = i_line_count;
                        fc = i_unit_count;
                    end
                    if (b < u8lc_pkg::ASCII_END) begin
                        v        = {13'd0, b};
                        do_count = 1'b1;
                    end else if (b >= u8lc_pkg::LEAD2_LO && b <= u8lc_pkg::LEAD2_HI) begin
                        dn.cont_left  = 2'd1;
                        dn.partial    = {16'd0, b[4:0]};
                        dn.lead_class = 2'd1;
                    end else if (b >= u8lc_pkg::LEAD3_LO && b <= u8lc_pkg::LEAD3_HI) begin
                        dn.cont_left  = 2'd2;
                        dn.partial    = {17'd0, b[3:0]};
                        dn.lead_class = 2'd2;
                    end else if (b >= u8lc_pkg::LEAD4_LO && b <= u8lc_pkg::LEAD4_HI) begin
                        dn.cont_left  = 2'd3;
                        dn.partial    = {18'd0, b[2:0]};
                        dn.lead_class = 2'd3;
                    end else begin
                        dn.encoding_bad = 1'b1;
                    end
                end
            end else begin
                if (hit) begin
                    dn.split_bad = 1'b1;
                end
                if ((b & u8lc_pkg::CONT_MASK) != u8lc_pkg::CONT_TAG) begin
                    // Drop the scalar and restart at the next byte
                    dn.encoding_bad = 1'b1;
                    dn.cont_left    = 2'd0;
                end else begin
                    dn.partial   = {i_dec.partial[14:0], b[5:0]};
                    dn.cont_left = i_dec.cont_left - 2'd1;
                    if (dn.cont_left == 2'd0) begin
                        if (dn.partial < u8lc_pkg::scalar_min(i_dec.lead_class) ||
                            dn.partial > u8lc_pkg::SCALAR_MAX ||
                            (dn.partial >= u8lc_pkg::SURR_LO &&
                             dn.partial <= u8lc_pkg::SURR_HI)) begin
                            dn.encoding_bad = 1'b1;
                        end else begin
                            v        = dn.partial;
                            do_count = 1'b1;
                        end
                    end
                end
            end

            // Advance line and UTF-16 unit counts for a completed scalar
            if (do_count) begin
                if (v == {13'd0, u8lc_pkg::BYTE_CR}) begin
                    lc          = i_line_count + COUNT_BITS'(1);
                    uc          = '0;
                    dn.after_cr = 1'b1;
                end else if (v == {13'd0, u8lc_pkg::BYTE_LF}) begin
                    lc = i_line_count + COUNT_BITS'(1);
                    uc = '0;
                end else if (v > u8lc_pkg::BMP_MAX) begin
                    uc = i_unit_count + COUNT_BITS'(2);
                end else begin
                    uc = i_unit_count + COUNT_BITS'(1);
                end
            end

            // A scalar cut off by the end of text
            if (i_item.is_last && dn.cont_left != 2'd0) begin
                dn.encoding_bad = 1'b1;
            end
        end
    end

    // Select the result from the updated state
    always_comb begin
        o_result.line_number  = '0;
        o_result.utf16_column = '0;
        if (dn.encoding_bad) begin
            o_result.status = u8lc_pkg::ST_BAD_UTF8;
        end else if (dn.split_bad) begin
            o_result.status = u8lc_pkg::ST_BOUNDARY;
        end else if (dn.target_found) begin
            o_result.status       = u8lc_pkg::ST_OK;
            o_result.line_number  = u8lc_pkg::OUT_BITS'(fl);
            o_result.utf16_column = u8lc_pkg::OUT_BITS'(fc);
        end else if (CMP_BITS'(bc) == w_target) begin
            o_result.status       = u8lc_pkg::ST_OK;
            o_result.line_number  = u8lc_pkg::OUT_BITS'(lc);
            o_result.utf16_column = u8lc_pkg::OUT_BITS'(uc);
        end else begin
            o_result.status = u8lc_pkg::ST_BOUNDARY;
        end
    end

    assign o_end          = i_item.is_last || i_item.text_empty;
    assign o_dec          = dn;
    assign o_byte_count   = bc;
    assign o_line_count   = lc;
    assign o_unit_count   = uc;
    assign o_found_line   = fl;
    assign o_found_column = fc;

endmodule

// ===== rtl/u8lc_out_reg.sv =====
// ----------------------------------------------------------------------------
// u8lc_out_reg
// Result register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module u8lc_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  u8lc_pkg::t_result i_result,
    output logic              o_free,
    u8lc_result_if.source     o_result
);

    logic              r_valid;
    u8lc_pkg::t_result r_result;

    // Free when empty or drained this cycle
    assign o_free = !r_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_result.valid        = r_valid;
    assign o_result.line_number  = r_result.line_number;
    assign o_result.utf16_column = r_result.utf16_column;
    assign o_result.status       = r_result.status;

endmodule

// ===== rtl/utf8_offset_to_line_utf16_column.sv =====
// ----------------------------------------------------------------------------
// utf8_offset_to_line_utf16_column
// Strict UTF-8 checker that reports the line and UTF-16 column of an offset.
// ----------------------------------------------------------------------------
// Feed the text one byte per transaction on i_text; is_last marks the final
// byte, and a transaction with text_empty set ends the text without a byte.
// The block takes one byte every cycle: each byte passes through an input
// register, combinational decode and counter update, and a result register;
// the single result of a text is loaded when its final byte leaves the input
// register, and the next text may start right behind it. A full result
// register stalls input only when an ending transaction needs it. CR, LF and
// CRLF each end a line; scalars above U+FFFF count two columns. Status 1 means
// invalid UTF-8 and wins over status 2, which means the target offset is not
// on a scalar boundary, lies past the end, or the text overran the byte
// counter. Write target_offset through i_cfg only while no text is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utf8_offset_to_line_utf16_column #(
    parameter int COUNT_BITS = u8lc_pkg::COUNT_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    u8lc_cfg_if.sink      i_cfg,
    u8lc_byte_if.sink     i_text,
    u8lc_result_if.source o_result
);

    logic                             r_in_valid;
    u8lc_pkg::t_item                  w_item;
    logic [u8lc_pkg::TARGET_BITS-1:0] r_target;

    u8lc_pkg::t_dec        r_dec, n_dec;
    logic [COUNT_BITS-1:0] r_byte_count, n_byte_count;
    logic [COUNT_BITS-1:0] r_line_count, n_line_count;
    logic [COUNT_BITS-1:0] r_unit_count, n_unit_count;
    logic [COUNT_BITS-1:0] r_found_line, n_found_line;
    logic [COUNT_BITS-1:0] r_found_column, n_found_column;

    logic              w_end, w_out_free, w_advance, w_load;
    u8lc_pkg::t_result w_result;
    logic              w_bad_result, w_no_position, w_cont_ok;

    // Configuration register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (i_cfg.valid) begin
            r_target <= i_cfg.data;
        end
    end

    u8lc_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_text    (i_text),
        .i_advance (w_advance),
        .o_valid   (r_in_valid),
        .o_item    (w_item)
    );

    u8lc_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .i_item         (w_item),
        .i_target       (r_target),
        .i_dec          (r_dec),
        .i_byte_count   (r_byte_count),
        .i_line_count   (r_line_count),
        .i_unit_count   (r_unit_count),
        .i_found_line   (r_found_line),
        .i_found_column (r_found_column),
        .o_dec          (n_dec),
        .o_byte_count   (n_byte_count),
        .o_line_count   (n_line_count),
        .o_unit_count   (n_unit_count),
        .o_found_line   (n_found_line),
        .o_found_column (n_found_column),
        .o_end          (w_end),
        .o_result       (w_result)
    );

    // Advance the held byte unless it ends the text and the result slot is busy
    assign w_advance = r_in_valid && (!w_end || w_out_free);
    assign w_load    = w_advance && w_end;

    // Decoder state and counters; clear after each result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec          <= '0;
            r_byte_count   <= '0;
            r_line_count   <= '0;
            r_unit_count   <= '0;
            r_found_line   <= '0;
            r_found_column <= '0;
        end else if (w_advance) begin
            if (w_end) begin
                r_dec          <= '0;
                r_byte_count   <= '0;
                r_line_count   <= '0;
                r_unit_count   <= '0;
                r_found_line   <= '0;
                r_found_column <= '0;
            end else begin
                r_dec          <= n_dec;
                r_byte_count   <= n_byte_count;
                r_line_count   <= n_line_count;
                r_unit_count   <= n_unit_count;
                r_found_line   <= n_found_line;
                r_found_column <= n_found_column;
            end
        end
    end

    u8lc_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_result (w_result),
        .o_free   (w_out_free),
        .o_result (o_result)
    );

    // Terms for the checks below
    assign w_bad_result  = o_result.valid && (o_result.status != u8lc_pkg::ST_OK);
    assign w_no_position = (o_result.line_number == '0) && (o_result.utf16_column == '0);
    assign w_cont_ok     = r_dec.cont_left <= r_dec.lead_class;

    // A new result only comes from an ending transaction that advanced
    `U8LC_ASSERT(a_result_source, i_clk, i_rst_n, $rose(o_result.valid) |-> $past(w_load))
    // State is back at reset values after each result
    `U8LC_ASSERT_NEXT(a_clear_after_end, i_clk, i_rst_n, w_load, r_byte_count == '0 && r_dec == '0)
    // Error results carry no position
    `U8LC_ASSERT(a_error_no_position, i_clk, i_rst_n, w_bad_result |-> w_no_position)
    // Pending continuation bytes never exceed what the lead announced
    `U8LC_ASSERT(a_cont_within_lead, i_clk, i_rst_n, (r_dec.cont_left != 2'd0) |-> w_cont_ok)

endmodule
